// ----- hdl/icaf_pkg.sv -----
`default_nettype none

package icaf_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_IW    = 5;   // indexes the 21-entry arctangent table in atan_ang
  localparam int VEC_W        = 32;
  localparam int ANG_W        = 24;
  localparam int MUL_A_W      = 32;
  localparam int MUL_B_W      = 18;
  localparam int PROD_W       = MUL_A_W + MUL_B_W;
  localparam int DLT_W        = 27;
  localparam int SUM_W        = 28;
  localparam int WIDE_W       = 35;
  localparam int CFG_AW       = 5;

  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [ANG_W-1:0]   ang_t;
  typedef logic signed [MUL_A_W-1:0] mul_a_t;
  typedef logic signed [MUL_B_W-1:0] mul_b_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [WIDE_W-1:0]  wide_t;

  localparam ang_t          ANG_HALF_PI     = 24'sd1647099;
  localparam ang_t          ANG_MAX         = 24'sd8388607;
  localparam ang_t          ANG_MIN         = -24'sd8388608;
  localparam logic [15:0]   CORDIC_INV_GAIN = 16'd39797;

  typedef struct packed {
    logic busy;
    logic done;
  } cord_stat_t;

  typedef enum logic [2:0] {
    REG_ACC_X_OFS  = 3'd0,
    REG_ACC_Y_OFS  = 3'd1,
    REG_ACC_Z_OFS  = 3'd2,
    REG_GYR_X_OFS  = 3'd3,
    REG_GYR_Z_OFS  = 3'd4,
    REG_STEP_GAIN  = 3'd5,
    REG_BLEND_GAIN = 3'd6,
    REG_YAW_DECAY  = 3'd7
  } reg_idx_t;

  // atan(2^-i) in 2^-20 rad
  function automatic ang_t atan_ang(input logic [CORDIC_IW-1:0] idx);
    ang_t res;
    case (idx)
      5'd0:    res = 24'sd823550;
      5'd1:    res = 24'sd486170;
      5'd2:    res = 24'sd256879;
      5'd3:    res = 24'sd130396;
      5'd4:    res = 24'sd65451;
      5'd5:    res = 24'sd32757;
      5'd6:    res = 24'sd16383;
      5'd7:    res = 24'sd8192;
      5'd8:    res = 24'sd4096;
      5'd9:    res = 24'sd2048;
      5'd10:   res = 24'sd1024;
      5'd11:   res = 24'sd512;
      5'd12:   res = 24'sd256;
      5'd13:   res = 24'sd128;
      5'd14:   res = 24'sd64;
      5'd15:   res = 24'sd32;
      5'd16:   res = 24'sd16;
      5'd17:   res = 24'sd8;
      5'd18:   res = 24'sd4;
      5'd19:   res = 24'sd2;
      5'd20:   res = 24'sd1;
      default: res = 24'sd0;
    endcase
    return res;
  endfunction

  function automatic ang_t sat_ang(input wide_t v);
    ang_t res;
    if (v > wide_t'(ANG_MAX)) begin
      res = ANG_MAX;
    end else if (v < wide_t'(ANG_MIN)) begin
      res = ANG_MIN;
    end else begin
      res = v[ANG_W-1:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/icaf_mul.sv -----
`default_nettype none

module icaf_mul (
  input  wire                   clk,
  input  icaf_pkg::mul_a_t      a,
  input  icaf_pkg::mul_b_t      b,
  output icaf_pkg::prod_t       prod
);

  icaf_pkg::prod_t prod_r;

  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- hdl/icaf_cordic.sv -----
`default_nettype none

module icaf_cordic (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  icaf_pkg::vec_t           x_in,
  input  icaf_pkg::vec_t           y_in,
  output icaf_pkg::cord_stat_t     stat,
  output icaf_pkg::ang_t           ang,
  output icaf_pkg::vec_t           mag
);

  icaf_pkg::vec_t            x_r;
  icaf_pkg::vec_t            y_r;
  icaf_pkg::ang_t            z_r;
  logic [icaf_pkg::CORDIC_IW-1:0] i_r;
  logic                      busy_r;
  logic                      done_r;
  logic                      zero_r;

  icaf_pkg::vec_t            x_pre;
  icaf_pkg::vec_t            y_pre;
  icaf_pkg::ang_t            z_pre;
  icaf_pkg::vec_t            xs;
  icaf_pkg::vec_t            ys;
  icaf_pkg::ang_t            at;
  logic                      last_step;

  // turn a vector in the left half plane by 90 degrees
  always_comb begin
    x_pre = x_in;
    y_pre = y_in;
    z_pre = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x_pre = y_in;
        y_pre = -x_in;
        z_pre = icaf_pkg::ANG_HALF_PI;
      end else begin
        x_pre = -y_in;
        y_pre = x_in;
        z_pre = -icaf_pkg::ANG_HALF_PI;
      end
    end
  end

  assign xs        = x_r >>> i_r;
  assign ys        = y_r >>> i_r;
  assign at        = icaf_pkg::atan_ang(i_r);
  assign last_step = (i_r == icaf_pkg::CORDIC_IW'(icaf_pkg::CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      zero_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        x_r    <= x_pre;
        y_r    <= y_pre;
        z_r    <= z_pre;
        zero_r <= (x_in == 0) && (y_in == 0);
        i_r    <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        if (zero_r) begin
          // zero vector: angle and magnitude stay zero
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          if (y_r > 0) begin
            x_r <= x_r + ys;
            y_r <= y_r - xs;
            z_r <= z_r + at;
          end else begin
            x_r <= x_r - ys;
            y_r <= y_r + xs;
            z_r <= z_r - at;
          end
          i_r <= i_r + 1'b1;
          if (last_step) begin
            busy_r <= 1'b0;
            done_r <= 1'b1;
          end
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign ang       = z_r;
  assign mag       = x_r;

`ifndef SYNTH
  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r)
    else $error("cordic done while still iterating");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("cordic started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("cordic done held longer than one cycle");
`endif

endmodule

`default_nettype wire

// ----- hdl/imu_complementary_attitude_filter_unit.sv -----
`default_nettype none

// Complementary attitude filter for one IMU sample per request. Calibration
// offsets are added to the raw accelerometer axes and the x and z gyro rates,
// the gyro rates are integrated into the kept roll, pitch and yaw estimates
// (24 bit, 2^-20 rad), roll and pitch are blended with accelerometer tilt
// from two CORDIC vectoring passes, and yaw decays by a forgetting factor.
// The two CORDIC passes run back to back on one shift-add unit and the nine
// multiplies share one registered multiplier. in_tready is high only while
// the sequencer is idle; the result sits in an output register, so a new
// request can be taken while the previous result waits. The user is to write
// configuration through the APB-style port only while no request is in
// flight; the block itself does not enforce it.
module imu_complementary_attitude_filter_unit (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // acc_x[15:0], acc_y[31:16], acc_z[47:32], rate_x[63:48], rate_y[79:64], rate_z[95:80]
  input  wire  [95:0]                       in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
  output logic [47:0]                       out_tdata,
  input  wire                               cfg_psel,
  input  wire                               cfg_penable,
  input  wire                               cfg_pwrite,
  input  wire  [icaf_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire  [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DR,
    ST_DP,
    ST_DY,
    ST_DY_WB,
    ST_C1_WAIT,
    ST_MAG,
    ST_MAG_WB,
    ST_C2_WAIT,
    ST_RG,
    ST_RA,
    ST_PG,
    ST_PA,
    ST_YG,
    ST_YW
  } state_t;

  state_t state_r;

  // configuration
  logic signed [15:0] ax_ofs_r;
  logic signed [15:0] ay_ofs_r;
  logic signed [15:0] az_ofs_r;
  logic signed [15:0] gx_ofs_r;
  logic signed [15:0] gz_ofs_r;
  logic [15:0]        step_gain_r;
  logic [15:0]        blend_r;
  logic [15:0]        decay_r;

  // captured sample
  logic signed [16:0] ax_r;
  logic signed [16:0] ay_r;
  logic signed [16:0] az_r;
  logic signed [16:0] gx_r;
  logic signed [16:0] ry_neg_r;
  logic signed [16:0] gz_r;

  logic signed [icaf_pkg::DLT_W-1:0] d_roll_r;
  logic signed [icaf_pkg::DLT_W-1:0] d_pitch_r;
  logic signed [icaf_pkg::DLT_W-1:0] d_yaw_r;
  icaf_pkg::ang_t  phi_r;
  icaf_pkg::ang_t  theta_r;
  icaf_pkg::prod_t acc_r;

  icaf_pkg::ang_t  roll_est_r;
  icaf_pkg::ang_t  pitch_est_r;
  icaf_pkg::ang_t  yaw_est_r;

  logic        out_valid_r;
  logic [47:0] out_data_r;

  logic signed [15:0] in_acc_x;
  logic signed [15:0] in_acc_y;
  logic signed [15:0] in_acc_z;
  logic signed [15:0] in_rate_x;
  logic signed [15:0] in_rate_y;
  logic signed [15:0] in_rate_z;

  logic                 in_accept;
  logic                 cfg_wr;
  icaf_pkg::reg_idx_t   cfg_idx;
  logic                 out_room;

  icaf_pkg::mul_a_t     mul_a;
  icaf_pkg::mul_b_t     mul_b;
  icaf_pkg::prod_t      prod;
  icaf_pkg::prod_t      prod_rnd8;
  icaf_pkg::prod_t      prod_rnd16;
  logic signed [icaf_pkg::PROD_W:0] blend_sum;
  icaf_pkg::ang_t       blend_new;
  icaf_pkg::ang_t       yaw_new;
  logic signed [icaf_pkg::DLT_W-1:0] dlt;
  logic signed [17:0]   gz_neg;
  logic signed [17:0]   az_neg;
  logic signed [17:0]   w_acc;
  logic signed [icaf_pkg::SUM_W-1:0] roll_sum;
  logic signed [icaf_pkg::SUM_W-1:0] pitch_sum;
  logic signed [icaf_pkg::SUM_W-1:0] yaw_sum;

  logic                 cord_start;
  icaf_pkg::vec_t       cord_x;
  icaf_pkg::vec_t       cord_y;
  icaf_pkg::cord_stat_t cord_stat;
  icaf_pkg::ang_t       cord_ang;
  icaf_pkg::vec_t       cord_mag;

  assign in_acc_x  = in_tdata[15:0];
  assign in_acc_y  = in_tdata[31:16];
  assign in_acc_z  = in_tdata[47:32];
  assign in_rate_x = in_tdata[63:48];
  assign in_rate_y = in_tdata[79:64];
  assign in_rate_z = in_tdata[95:80];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_room   = !out_valid_r || out_tready;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = icaf_pkg::reg_idx_t'(cfg_paddr[4:2]);

  always_comb begin
    case (cfg_idx)
      icaf_pkg::REG_ACC_X_OFS:  cfg_prdata = 32'(ax_ofs_r);
      icaf_pkg::REG_ACC_Y_OFS:  cfg_prdata = 32'(ay_ofs_r);
      icaf_pkg::REG_ACC_Z_OFS:  cfg_prdata = 32'(az_ofs_r);
      icaf_pkg::REG_GYR_X_OFS:  cfg_prdata = 32'(gx_ofs_r);
      icaf_pkg::REG_GYR_Z_OFS:  cfg_prdata = 32'(gz_ofs_r);
      icaf_pkg::REG_STEP_GAIN:  cfg_prdata = {16'b0, step_gain_r};
      icaf_pkg::REG_BLEND_GAIN: cfg_prdata = {16'b0, blend_r};
      icaf_pkg::REG_YAW_DECAY:  cfg_prdata = {16'b0, decay_r};
      default:                  cfg_prdata = '0;
    endcase
  end

  assign gz_neg    = -18'(gz_r);
  assign az_neg    = -18'(az_r);
  assign w_acc     = 18'sd65536 - $signed({2'b00, blend_r});
  assign roll_sum  = icaf_pkg::SUM_W'(roll_est_r) + icaf_pkg::SUM_W'(d_roll_r);
  assign pitch_sum = icaf_pkg::SUM_W'(pitch_est_r) + icaf_pkg::SUM_W'(d_pitch_r);
  assign yaw_sum   = icaf_pkg::SUM_W'(yaw_est_r) + icaf_pkg::SUM_W'(d_yaw_r);

  // operand select for the shared multiplier
  always_comb begin
    case (state_r)
      ST_DR: begin
        mul_a = icaf_pkg::mul_a_t'(ry_neg_r);
        mul_b = $signed({2'b00, step_gain_r});
      end
      ST_DP: begin
        mul_a = icaf_pkg::mul_a_t'(gx_r);
        mul_b = $signed({2'b00, step_gain_r});
      end
      ST_DY: begin
        mul_a = icaf_pkg::mul_a_t'(gz_neg);
        mul_b = $signed({2'b00, step_gain_r});
      end
      ST_MAG: begin
        mul_a = cord_mag;
        mul_b = $signed({2'b00, icaf_pkg::CORDIC_INV_GAIN});
      end
      ST_RG: begin
        mul_a = icaf_pkg::mul_a_t'(roll_sum);
        mul_b = $signed({2'b00, blend_r});
      end
      ST_RA: begin
        mul_a = icaf_pkg::mul_a_t'(phi_r);
        mul_b = w_acc;
      end
      ST_PG: begin
        mul_a = icaf_pkg::mul_a_t'(pitch_sum);
        mul_b = $signed({2'b00, blend_r});
      end
      ST_PA: begin
        mul_a = icaf_pkg::mul_a_t'(theta_r);
        mul_b = w_acc;
      end
      ST_YG, ST_YW: begin
        mul_a = icaf_pkg::mul_a_t'(yaw_sum);
        mul_b = $signed({2'b00, decay_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  icaf_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign prod_rnd8  = prod + icaf_pkg::PROD_W'(128);
  assign prod_rnd16 = prod + icaf_pkg::PROD_W'(32768);
  assign dlt        = prod_rnd8[icaf_pkg::DLT_W+7:8];
  assign blend_sum  = {acc_r[icaf_pkg::PROD_W-1], acc_r} + {prod[icaf_pkg::PROD_W-1], prod};
  assign blend_new  = icaf_pkg::sat_ang(blend_sum[icaf_pkg::PROD_W:16]);
  assign yaw_new    = icaf_pkg::sat_ang({prod_rnd16[icaf_pkg::PROD_W-1],
                                         prod_rnd16[icaf_pkg::PROD_W-1:16]});

  // first pass: atan2(ax, -az); second pass: atan2(ay, corrected magnitude)
  always_comb begin
    cord_start = 1'b0;
    cord_x     = {{2{az_neg[17]}}, az_neg, 12'b0};
    cord_y     = {{3{ax_r[16]}}, ax_r, 12'b0};
    case (state_r)
      ST_DY_WB: begin
        cord_start = 1'b1;
      end
      ST_MAG_WB: begin
        cord_start = 1'b1;
        cord_x     = prod_rnd16[icaf_pkg::VEC_W+15:16];
        cord_y     = {{3{ay_r[16]}}, ay_r, 12'b0};
      end
      default: begin
        cord_start = 1'b0;
      end
    endcase
  end

  icaf_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .x_in  (cord_x),
    .y_in  (cord_y),
    .stat  (cord_stat),
    .ang   (cord_ang),
    .mag   (cord_mag)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      ax_ofs_r    <= 16'sd143;
      ay_ofs_r    <= 16'sd184;
      az_ofs_r    <= -16'sd369;
      gx_ofs_r    <= 16'sd19;
      gz_ofs_r    <= -16'sd10;
      step_gain_r <= 16'd586;
      blend_r     <= 16'd64250;
      decay_r     <= 16'd64880;
      roll_est_r  <= '0;
      pitch_est_r <= '0;
      yaw_est_r   <= '0;
    end else begin
      if (cfg_wr) begin
        case (cfg_idx)
          icaf_pkg::REG_ACC_X_OFS:  ax_ofs_r    <= cfg_pwdata[15:0];
          icaf_pkg::REG_ACC_Y_OFS:  ay_ofs_r    <= cfg_pwdata[15:0];
          icaf_pkg::REG_ACC_Z_OFS:  az_ofs_r    <= cfg_pwdata[15:0];
          icaf_pkg::REG_GYR_X_OFS:  gx_ofs_r    <= cfg_pwdata[15:0];
          icaf_pkg::REG_GYR_Z_OFS:  gz_ofs_r    <= cfg_pwdata[15:0];
          icaf_pkg::REG_STEP_GAIN:  step_gain_r <= cfg_pwdata[15:0];
          icaf_pkg::REG_BLEND_GAIN: blend_r     <= cfg_pwdata[15:0];
          icaf_pkg::REG_YAW_DECAY:  decay_r     <= cfg_pwdata[15:0];
          default: ;
        endcase
      end

      // drop the taken result unless a new one is loaded in this cycle
      if (out_valid_r && out_tready && state_r != ST_YW) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_accept) begin
            ax_r     <= 17'(in_acc_x) + 17'(ax_ofs_r);
            ay_r     <= 17'(in_acc_y) + 17'(ay_ofs_r);
            az_r     <= 17'(in_acc_z) + 17'(az_ofs_r);
            gx_r     <= 17'(in_rate_x) + 17'(gx_ofs_r);
            ry_neg_r <= -17'(in_rate_y);
            gz_r     <= 17'(in_rate_z) + 17'(gz_ofs_r);
            state_r  <= ST_DR;
          end
        end
        ST_DR: state_r <= ST_DP;
        ST_DP: begin
          d_roll_r <= dlt;
          state_r  <= ST_DY;
        end
        ST_DY: begin
          d_pitch_r <= dlt;
          state_r   <= ST_DY_WB;
        end
        ST_DY_WB: begin
          d_yaw_r <= dlt;
          state_r <= ST_C1_WAIT;
        end
        ST_C1_WAIT: begin
          if (cord_stat.done) begin
            phi_r   <= cord_ang;
            state_r <= ST_MAG;
          end
        end
        ST_MAG:    state_r <= ST_MAG_WB;
        ST_MAG_WB: state_r <= ST_C2_WAIT;
        ST_C2_WAIT: begin
          if (cord_stat.done) begin
            theta_r <= cord_ang;
            state_r <= ST_RG;
          end
        end
        ST_RG: state_r <= ST_RA;
        ST_RA: begin
          acc_r   <= prod_rnd16;
          state_r <= ST_PG;
        end
        ST_PG: begin
          roll_est_r <= blend_new;
          state_r    <= ST_PA;
        end
        ST_PA: begin
          acc_r   <= prod_rnd16;
          state_r <= ST_YG;
        end
        ST_YG: begin
          pitch_est_r <= blend_new;
          state_r     <= ST_YW;
        end
        ST_YW: begin
          // hold until the output register is free
          if (out_room) begin
            yaw_est_r   <= yaw_new;
            out_data_r  <= {yaw_new[23:8], pitch_est_r[23:8], roll_est_r[23:8]};
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_start_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cord_start |-> !cord_stat.busy)
    else $error("cordic pass started while the previous one runs");

  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    cord_stat.done |-> (state_r == ST_C1_WAIT || state_r == ST_C2_WAIT))
    else $error("cordic result arrived outside a wait state");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> !in_tready)
    else $error("new request taken right after accept");
`endif

endmodule

`default_nettype wire

// ----- dv/icaf_attitude_checker.sv -----
`timescale 1ns / 100ps

module icaf_attitude_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  // acc_x[15:0], acc_y[31:16], acc_z[47:32], rate_x[63:48], rate_y[79:64], rate_z[95:80]
  input  logic [95:0]                 in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  // roll_angle[15:0], pitch_angle[31:16], yaw_angle[47:32]
  input  logic [47:0]                 out_tdata,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic                        cfg_pready,
  input  logic [icaf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output int                          pending,
  output int                          fail_count
);

  typedef struct packed {
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] roll;
  } attitude_t;

  localparam longint QUARTER_TURN = 1647099;
  localparam longint MAG_TRIM     = 39797;   // 1/K of the vectoring pass, Q0.16
  localparam longint ARCTAN_LUT [24] = '{
    823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
    4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2, 1, 0, 0, 0
  };

  logic signed [15:0] acc_x_ofs, acc_y_ofs, acc_z_ofs, gyr_x_ofs, gyr_z_ofs;
  logic [15:0]        step_gain, blend_gain, yaw_decay;
  icaf_pkg::ang_t     roll_est, pitch_est, yaw_est;
  attitude_t          attitude_q [$];

  // Vectoring pass: angle of (x, y) in 2^-20 rad, len gets the K-scaled length.
  function automatic longint tilt_angle(input longint y_in, input longint x_in,
                                        output longint len);
    longint x, y, z, xs, ys, t;
    x = x_in;
    y = y_in;
    z = 0;
    len = 0;
    if (x == 0 && y == 0) begin
      return 0;
    end
    // turn a left half-plane vector by a quarter turn first
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = QUARTER_TURN;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < icaf_pkg::CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ARCTAN_LUT[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ARCTAN_LUT[i];
      end
    end
    len = x;
    return z;
  endfunction

  function automatic icaf_pkg::ang_t clamp_angle(input longint v);
    icaf_pkg::ang_t res;
    if (v > longint'(icaf_pkg::ANG_MAX)) begin
      res = icaf_pkg::ANG_MAX;
    end else if (v < longint'(icaf_pkg::ANG_MIN)) begin
      res = icaf_pkg::ANG_MIN;
    end else begin
      res = icaf_pkg::ang_t'(v);
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    attitude_t want, got;
    longint    ax, ay, az, gx, ry, gz, d_roll, d_pitch, d_yaw;
    longint    phi, theta, len, r, spare, bl, wa, sg;
    if (!rst_n) begin
      acc_x_ofs = 16'sd143;
      acc_y_ofs = 16'sd184;
      acc_z_ofs = -16'sd369;
      gyr_x_ofs = 16'sd19;
      gyr_z_ofs = -16'sd10;
      step_gain = 16'd586;
      blend_gain = 16'd64250;
      yaw_decay = 16'd64880;
      roll_est = '0;
      pitch_est = '0;
      yaw_est = '0;
      attitude_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (attitude_q.size() == 0) begin
          $error("result with no request pending: %h", out_tdata);
          fail_count++;
        end else begin
          want = attitude_q.pop_front();
          check_field("roll_angle", want.roll, got.roll);
          check_field("pitch_angle", want.pitch, got.pitch);
          check_field("yaw_angle", want.yaw, got.yaw);
        end
      end

      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (icaf_pkg::reg_idx_t'(cfg_paddr[icaf_pkg::CFG_AW-1:2]))
          icaf_pkg::REG_ACC_X_OFS:  acc_x_ofs = cfg_pwdata[15:0];
          icaf_pkg::REG_ACC_Y_OFS:  acc_y_ofs = cfg_pwdata[15:0];
          icaf_pkg::REG_ACC_Z_OFS:  acc_z_ofs = cfg_pwdata[15:0];
          icaf_pkg::REG_GYR_X_OFS:  gyr_x_ofs = cfg_pwdata[15:0];
          icaf_pkg::REG_GYR_Z_OFS:  gyr_z_ofs = cfg_pwdata[15:0];
          icaf_pkg::REG_STEP_GAIN:  step_gain = cfg_pwdata[15:0];
          icaf_pkg::REG_BLEND_GAIN: blend_gain = cfg_pwdata[15:0];
          icaf_pkg::REG_YAW_DECAY:  yaw_decay = cfg_pwdata[15:0];
          default: ;
        endcase
      end

      if (in_tvalid && in_tready) begin
        ax = longint'($signed(in_tdata[15:0])) + longint'(acc_x_ofs);
        ay = longint'($signed(in_tdata[31:16])) + longint'(acc_y_ofs);
        az = longint'($signed(in_tdata[47:32])) + longint'(acc_z_ofs);
        gx = longint'($signed(in_tdata[63:48])) + longint'(gyr_x_ofs);
        ry = longint'($signed(in_tdata[79:64]));
        gz = longint'($signed(in_tdata[95:80])) + longint'(gyr_z_ofs);
        sg = longint'(step_gain);
        bl = longint'(blend_gain);
        wa = 65536 - bl;

        // body-frame remap: roll follows -rate_y, pitch rate_x, yaw -rate_z
        d_roll = (-ry * sg + 128) >>> 8;
        d_pitch = (gx * sg + 128) >>> 8;
        d_yaw = (-gz * sg + 128) >>> 8;

        phi = tilt_angle(ax * 4096, -az * 4096, len);
        r = (len * MAG_TRIM + 32768) >>> 16;
        theta = tilt_angle(ay * 4096, r, spare);

        roll_est = clamp_angle(((longint'(roll_est) + d_roll) * bl + phi * wa + 32768) >>> 16);
        pitch_est = clamp_angle(((longint'(pitch_est) + d_pitch) * bl + theta * wa + 32768)
                                >>> 16);
        yaw_est = clamp_angle(((longint'(yaw_est) + d_yaw) * longint'(yaw_decay) + 32768)
                              >>> 16);

        want.roll = roll_est[23:8];
        want.pitch = pitch_est[23:8];
        want.yaw = yaw_est[23:8];
        attitude_q.push_back(want);
      end
    end
    pending <= attitude_q.size();
  end

endmodule

// ----- dv/tb_imu_complementary_attitude_filter_unit.sv -----
`timescale 1ns / 100ps

module tb_imu_complementary_attitude_filter_unit;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_COMB} sink_mode_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_tvalid;
  logic                        in_tready;
  logic [95:0]                 in_tdata;
  logic                        out_tvalid;
  logic                        out_tready;
  logic [47:0]                 out_tdata;
  logic                        cfg_psel;
  logic                        cfg_penable;
  logic                        cfg_pwrite;
  logic [icaf_pkg::CFG_AW-1:0] cfg_paddr;
  logic [31:0]                 cfg_pwdata;
  logic [31:0]                 cfg_prdata;
  logic                        cfg_pready;
  int                          pending;
  int                          fail_count;

  // register values currently loaded, indexed by register
  logic [15:0] reg_now [8] = '{16'd143, 16'd184, 16'hfe8f, 16'd19, 16'hfff6,
                               16'd586, 16'd64250, 16'd64880};
  bit          gaps_on;
  int          burst_left;

  imu_complementary_attitude_filter_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  icaf_attitude_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_pready  (cfg_pready),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .pending     (pending),
    .fail_count  (fail_count)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [15:0] corner_word();
    logic [15:0] w;
    case ($urandom_range(0, 4))
      0: w = 16'h8000;
      1: w = 16'h7fff;
      2: w = 16'h0000;
      3: w = 16'hffff;
      default: w = 16'h0001;
    endcase
    return w;
  endfunction

  // Offer one request and return at the edge that takes it.
  task automatic send_sample(input logic [95:0] d);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 70);
      end
    end
    burst_left--;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    do @(posedge clk); while (!in_tready);
  endtask

  // Accel given as offset-corrected sums; gyro given raw.
  task automatic send_tilt(input int ax, input int ay, input int az,
                           input logic [15:0] rx, input logic [15:0] ry,
                           input logic [15:0] rz);
    logic [15:0] raw_x, raw_y, raw_z;
    raw_x = 16'(ax - $signed(reg_now[icaf_pkg::REG_ACC_X_OFS]));
    raw_y = 16'(ay - $signed(reg_now[icaf_pkg::REG_ACC_Y_OFS]));
    raw_z = 16'(az - $signed(reg_now[icaf_pkg::REG_ACC_Z_OFS]));
    send_sample({rz, ry, rx, raw_z, raw_y, raw_x});
  endtask

  initial begin : result_sink
    int         seen;
    int         next_hold;
    int         hold_left;
    longint     cyc;
    sink_mode_t mode;
    seen = 0;
    next_hold = 150;
    hold_left = 0;
    cyc = 0;
    mode = SINK_OPEN;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (out_tvalid && out_tready) begin
        seen++;
      end
      // hold off long enough for the block to back up into its input
      if (seen == next_hold) begin
        hold_left = 400;
        next_hold = next_hold + 500;
      end
      if (cyc % 97 == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          SINK_OPEN:   out_tready <= 1'b1;
          SINK_COIN:   out_tready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
          default:     out_tready <= ((cyc % 8) < 3);
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [15:0]        vals [8];
    logic [95:0]        s;
    int                 kind;
    icaf_pkg::reg_idx_t ri;

    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    gaps_on = 1'b1;
    burst_left = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed requests on the reset register values
    send_tilt(0, 0, 0, 16'h0000, 16'h0000, 16'h0000);        // zero accel vector
    send_tilt(0, 0, 0, 16'h7fff, 16'h8000, 16'h7fff);
    send_tilt(0, 0, 2048, 16'h0010, 16'hfff0, 16'h0000);     // negative x axis, +pi
    send_tilt(0, 0, -2048, 16'hfff0, 16'h0010, 16'h0100);
    send_tilt(1200, 0, 2048, 16'h0000, 16'h0000, 16'h0000);
    send_tilt(-1200, 0, 2048, 16'h0000, 16'h0000, 16'h0000);
    send_tilt(0, 2048, 0, 16'h0040, 16'h0040, 16'h0040);     // CORDIC x input zero
    send_tilt(0, -2048, 0, 16'hffc0, 16'hffc0, 16'hffc0);
    send_tilt(-300, 500, -2000, 16'h0123, 16'hfedc, 16'h0456);
    send_sample({6{16'h7fff}});
    send_sample({6{16'h8000}});
    send_sample({3{16'h8000, 16'h7fff}});
    send_sample('0);
    send_sample({6{16'hffff}});
    send_sample({6{16'h0001}});

    for (int setting_no = 0; setting_no < 10; setting_no++) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      wait (pending == 0);

      for (int k = 0; k < 8; k++) begin
        ri = icaf_pkg::reg_idx_t'(k);
        case (setting_no)
          0: vals[k] = (ri <= icaf_pkg::REG_GYR_Z_OFS || ri == icaf_pkg::REG_BLEND_GAIN)
                       ? 16'h0000 : 16'hffff;
          1: vals[k] = (ri <= icaf_pkg::REG_GYR_Z_OFS) ? 16'h8000 :
                       (ri == icaf_pkg::REG_BLEND_GAIN) ? 16'hffff : 16'h0000;
          2: vals[k] = (ri <= icaf_pkg::REG_GYR_Z_OFS) ? 16'h7fff : 16'hffff;
          default: vals[k] = ($urandom_range(0, 3) == 0) ? corner_word() : 16'($urandom);
        endcase
      end

      for (int k = 0; k < 8; k++) begin
        ri = icaf_pkg::reg_idx_t'(k);
        cfg_psel <= 1'b1;
        cfg_penable <= 1'b0;
        cfg_pwrite <= 1'b1;
        cfg_paddr <= {ri, 2'b00};
        cfg_pwdata <= (ri <= icaf_pkg::REG_GYR_Z_OFS) ? {{16{vals[k][15]}}, vals[k]}
                                                       : {16'h0000, vals[k]};
        @(posedge clk);
        cfg_penable <= 1'b1;
        do @(posedge clk); while (!cfg_pready);
        reg_now[k] = vals[k];
      end
      cfg_psel <= 1'b0;
      cfg_penable <= 1'b0;
      cfg_pwrite <= 1'b0;

      gaps_on = (setting_no % 3 != 2);
      burst_left = 0;

      repeat (140) begin
        s = {$urandom, $urandom, $urandom};
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
          for (int k = 0; k < 6; k++) begin
            s[16*k +: 16] = corner_word();
          end
        end else if (kind < 25) begin
          // cancel the offsets: zero x axis, sometimes the whole accel vector
          s[15:0] = 16'(-$signed(reg_now[icaf_pkg::REG_ACC_X_OFS]));
          if (kind < 20) begin
            s[31:16] = 16'(-$signed(reg_now[icaf_pkg::REG_ACC_Y_OFS]));
            s[47:32] = 16'(-$signed(reg_now[icaf_pkg::REG_ACC_Z_OFS]));
          end
        end else if (kind < 55) begin
          // about one g per axis with modest rates
          for (int k = 0; k < 3; k++) begin
            s[16*k +: 16] = 16'(int'($urandom_range(0, 8192)) - 4096 - $signed(reg_now[k]));
          end
          for (int k = 3; k < 6; k++) begin
            s[16*k +: 16] = 16'(int'($urandom_range(0, 4000)) - 2000);
          end
        end
        send_sample(s);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/icaf_pkg.sv
hdl/icaf_mul.sv
hdl/icaf_cordic.sv
hdl/imu_complementary_attitude_filter_unit.sv
dv/icaf_attitude_checker.sv
dv/tb_imu_complementary_attitude_filter_unit.sv
